// ===== rtl/gvpa_pkg.sv =====
// ----------------------------------------------------------------------------
// gvpa_pkg
// Shared types and constants of the graphic plane access port.
// ----------------------------------------------------------------------------
package gvpa_pkg;

  localparam int unsigned ADDR_W       = 21;
  localparam int unsigned DATA_W       = 16;
  localparam int unsigned WINDOW_BYTES = 524288;
  // window size is a power of two, so the window number is a plain bit field
  localparam int unsigned WIN_SHIFT    = $clog2(WINDOW_BYTES);
  localparam int unsigned VRAM_WORDS   = 262144;
  localparam int unsigned IDX_W        = $clog2(VRAM_WORDS);

  localparam logic [1:0] COLOR_16  = 2'd0;
  localparam logic [1:0] COLOR_256 = 2'd1;

  localparam logic [DATA_W-1:0] MASK_NIBBLE = 16'h000F;
  localparam logic [DATA_W-1:0] MASK_BYTE   = 16'h00FF;
  localparam logic [DATA_W-1:0] MASK_WORD   = 16'hFFFF;
  localparam logic [DATA_W-1:0] MASK_UPPER  = 16'hFF00;

  typedef enum logic [1:0] {
    MODE_RD_BYTE = 2'd0,
    MODE_RD_WORD = 2'd1,
    MODE_WR_BYTE = 2'd2,
    MODE_WR_WORD = 2'd3
  } gvpa_mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } gvpa_state_e;

  typedef struct packed {
    logic clr_we;  // write zero at the clear counter
    logic acc;     // take the request and read its word
    logic exec;    // modify, write back and present the result
  } gvpa_cmd_t;

  typedef struct packed {
    logic clr_last;
  } gvpa_sts_t;

endpackage

// ===== rtl/graphic_vram_plane_access.sv =====
// ----------------------------------------------------------------------------
// graphic_vram_plane_access
// Byte and word access to four aliased graphic windows over one word store.
// ----------------------------------------------------------------------------
//  channel   | ports                                        | handshake
//  ----------+----------------------------------------------+------------------
//  request   | byte_address_i, mode_i, write_data_i         | start && !busy
//  result    | read_data_o                                  | result_valid_o
//  config    | color_mode_i                                 | color_mode_we_i
//
//  A request reads its word from the store port at acceptance, then the
//  word is modified and written back in the next cycle; busy is high in
//  that cycle and the result strobe follows in the cycle after it.
//  After reset the store is cleared one word a cycle with busy high;
//  color mode writes are taken at any time.
//  The receiver cannot stall, so each result shows for a single cycle.
// ----------------------------------------------------------------------------
module graphic_vram_plane_access
  import gvpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              color_mode_we_i,
  input  logic [1:0]        color_mode_i,
  input  logic              start,
  output logic              busy,
  input  logic [ADDR_W-1:0] byte_address_i,
  input  logic [1:0]        mode_i,
  input  logic [DATA_W-1:0] write_data_i,
  output logic              result_valid_o,
  output logic [DATA_W-1:0] read_data_o
);

  gvpa_cmd_t cmd;
  gvpa_sts_t sts;

  gvpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  gvpa_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .color_mode_we_i (color_mode_we_i),
    .color_mode_i    (color_mode_i),
    .byte_address_i  (byte_address_i),
    .mode_i          (mode_i),
    .write_data_i    (write_data_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .read_data_o     (read_data_o)
  );

  ap_result_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, 2))
    else $error("result without a request two cycles earlier");

  ap_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !cmd.acc)
    else $error("request accepted while the previous one is in flight");

  ap_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/gvpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gvpa_ctrl
// Sequencer: clearing pass after reset, then read and write-back per request.
// ----------------------------------------------------------------------------
module gvpa_ctrl
  import gvpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  gvpa_sts_t sts_i,
  output gvpa_cmd_t cmd_o
);

  gvpa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.acc = 1'b1;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ap_exec_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC |=> state_q == ST_IDLE)
    else $error("exec state held longer than one cycle");

  ap_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR && !sts_i.clr_last |=> state_q == ST_CLEAR)
    else $error("clearing pass left early");

endmodule

// ===== rtl/gvpa_datapath.sv =====
// ----------------------------------------------------------------------------
// gvpa_datapath
// Word store, page field selection, read-modify-write and result register.
// ----------------------------------------------------------------------------
module gvpa_datapath
  import gvpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              color_mode_we_i,
  input  logic [1:0]        color_mode_i,
  input  logic [ADDR_W-1:0] byte_address_i,
  input  logic [1:0]        mode_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  gvpa_cmd_t         cmd_i,
  output gvpa_sts_t         sts_o,
  output logic              result_valid_o,
  output logic [DATA_W-1:0] read_data_o
);

  logic [DATA_W-1:0] mem_q [VRAM_WORDS];

  logic [1:0]        color_mode_q;
  logic [IDX_W-1:0]  clr_cnt_q;
  logic [ADDR_W-1:0] addr_q;
  gvpa_mode_e        mode_q;
  logic [DATA_W-1:0] wdata_q;
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] read_data_q, read_data_d;
  logic              valid_q;

  logic [ADDR_W-1:0] in_off, in_idx_full, win_full;
  logic [IDX_W-1:0]  in_idx, idx_q;
  logic [1:0]        win;
  logic [3:0]        sh;
  logic [DATA_W-1:0] mask, dot, field, next_dot, new_word;
  logic              high;

  // word index straight from the request, so the read starts at acceptance
  assign in_off      = byte_address_i & ADDR_W'(WINDOW_BYTES - 1);
  assign in_idx_full = in_off >> 1;
  assign in_idx      = in_idx_full[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= COLOR_16;
      clr_cnt_q    <= '0;
      valid_q      <= 1'b0;
    end else begin
      if (color_mode_we_i) begin
        color_mode_q <= color_mode_i;
      end
      if (cmd_i.clr_we) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      valid_q <= cmd_i.exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      addr_q  <= byte_address_i;
      idx_q   <= in_idx;
      mode_q  <= gvpa_mode_e'(mode_i);
      wdata_q <= write_data_i;
    end
    if (cmd_i.exec) begin
      read_data_q <= read_data_d;
    end
  end

  // word store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_we) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.exec && mode_q[1]) begin
      mem_q[idx_q] <= new_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc) begin
      rdata_q <= mem_q[in_idx];
    end
  end

  assign sts_o.clr_last = &clr_cnt_q;

  assign win_full = addr_q >> WIN_SHIFT;
  assign win      = win_full[1:0];
  assign high     = ~addr_q[0];

  always_comb begin
    case (color_mode_q)
      COLOR_16: begin
        sh   = {win, 2'b00};
        mask = MASK_NIBBLE;
      end
      COLOR_256: begin
        sh   = {win[0], 3'b000};
        mask = MASK_BYTE;
      end
      default: begin
        sh   = 4'd0;
        mask = MASK_WORD;
      end
    endcase
  end

  assign dot   = (rdata_q >> sh) & mask;
  assign field = mask << sh;

  always_comb begin
    read_data_d = '0;
    next_dot    = wdata_q;
    case (mode_q)
      MODE_RD_BYTE: begin
        read_data_d = high ? (dot >> 8) : (dot & MASK_BYTE);
      end
      MODE_RD_WORD: begin
        read_data_d = dot;
      end
      MODE_WR_BYTE: begin
        // even address replaces the upper byte of the dot
        next_dot = high ? {wdata_q[7:0], dot[7:0]}
                        : ((dot & MASK_UPPER) | {8'h00, wdata_q[7:0]});
      end
      MODE_WR_WORD: begin
        next_dot = wdata_q;
      end
      default: begin
        read_data_d = '0;
      end
    endcase
  end

  assign new_word = (rdata_q & ~field) | ((next_dot & mask) << sh);

  assign result_valid_o = valid_q;
  assign read_data_o    = read_data_q;

endmodule

// ===== verif/plane_access_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plane_access_checker
// Follows every request and color mode write into its own copy of the word
// store, works out the read data each request should return and compares it
// with the result strobes of the block.
// ----------------------------------------------------------------------------
module plane_access_checker
  import gvpa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              color_mode_we_i,
  input  logic [1:0]        color_mode_i,
  input  logic              start,
  input  logic              busy,
  input  logic [ADDR_W-1:0] byte_address_i,
  input  logic [1:0]        mode_i,
  input  logic [DATA_W-1:0] write_data_i,
  input  logic              result_valid_o,
  input  logic [DATA_W-1:0] read_data_o,
  output int                pending_o,
  output int                fail_count_o
);

  bit   [DATA_W-1:0] plane_words [VRAM_WORDS];
  logic [1:0]        active_color;
  logic [DATA_W-1:0] read_data_due [$];

  // word index, field shift and field mask that one byte address selects
  function automatic void page_lane(input logic [ADDR_W-1:0] addr,
                                    output int unsigned idx,
                                    output int unsigned sh,
                                    output logic [DATA_W-1:0] m);
    int unsigned win;
    win = (int'(addr) >> WIN_SHIFT) & 3;
    idx = ((int'(addr) % WINDOW_BYTES) >> 1) % VRAM_WORDS;
    case (active_color)
      COLOR_16: begin
        sh = win * 4;
        m  = MASK_NIBBLE;
      end
      COLOR_256: begin
        sh = (win & 1) * 8;
        m  = MASK_BYTE;
      end
      default: begin
        sh = 0;
        m  = MASK_WORD;
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] serve_access(input logic [ADDR_W-1:0] addr,
                                                     input gvpa_mode_e op,
                                                     input logic [DATA_W-1:0] data);
    int unsigned       idx;
    int unsigned       sh;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] dot;
    logic [DATA_W-1:0] field;
    logic [DATA_W-1:0] dot_next;
    logic              upper;
    logic              do_write;
    logic [DATA_W-1:0] result;
    page_lane(addr, idx, sh, m);
    dot      = (plane_words[idx] >> sh) & m;
    upper    = ~addr[0];
    do_write = 1'b0;
    result   = '0;
    dot_next = '0;
    case (op)
      MODE_RD_BYTE: result = upper ? ((dot >> 8) & MASK_BYTE) : (dot & MASK_BYTE);
      MODE_RD_WORD: result = dot;
      MODE_WR_BYTE: begin
        // even address replaces the upper byte of the dot, odd the lower one
        dot_next = upper ? {data[7:0], dot[7:0]} : {dot[15:8], data[7:0]};
        do_write = 1'b1;
      end
      default: begin
        dot_next = data;
        do_write = 1'b1;
      end
    endcase
    if (do_write) begin
      field            = m << sh;
      plane_words[idx] = (plane_words[idx] & ~field) | ((dot_next & m) << sh);
    end
    return result;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (plane_words[i]) plane_words[i] = '0;
      active_color = COLOR_16;
      read_data_due.delete();
      fail_count_o = 0;
    end else begin
      if (result_valid_o) begin
        if (read_data_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got read_data %h",
                   $time, read_data_o);
          fail_count_o++;
        end else begin
          if (read_data_o !== read_data_due[0]) begin
            $display("%0t read_data mismatch: expected %h, got %h",
                     $time, read_data_due[0], read_data_o);
            fail_count_o++;
          end
          void'(read_data_due.pop_front());
        end
      end
      if (start && !busy)
        read_data_due.push_back(serve_access(byte_address_i, gvpa_mode_e'(mode_i),
                                             write_data_i));
      if (color_mode_we_i) active_color = color_mode_i;
    end
    pending_o = read_data_due.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives byte and word reads and writes into the graphic plane access port
// under all color modes, with directed corner requests first and then random
// requests mostly over a small set of hot words, while the checker scores results.
// ----------------------------------------------------------------------------
module tb;
  import gvpa_pkg::*;

  localparam logic [1:0] COLOR_RSVD = 2'd2;
  localparam logic [1:0] COLOR_65K  = 2'd3;
  localparam int         SEGMENTS   = 8;
  localparam int         SEG_ITEMS  = 212;
  localparam int         HOT_WORDS  = 12;

  logic              clk_i;
  logic              rst_ni;
  logic              color_mode_we_i;
  logic [1:0]        color_mode_i;
  logic              start;
  logic              busy;
  logic [ADDR_W-1:0] byte_address_i;
  logic [1:0]        mode_i;
  logic [DATA_W-1:0] write_data_i;
  logic              result_valid_o;
  logic [DATA_W-1:0] read_data_o;
  logic              req_taken;
  int                pending;
  int                fail_count;
  int unsigned       hot_idx [HOT_WORDS];

  graphic_vram_plane_access dut (.*);

  plane_access_checker checker_i (
    .clk_i, .rst_ni, .color_mode_we_i, .color_mode_i, .start, .busy,
    .byte_address_i, .mode_i, .write_data_i, .result_valid_o, .read_data_o,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #12_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // a request is taken at an edge where start is high and busy low
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
    end
  end

  task automatic send_access(input logic [ADDR_W-1:0] addr, input gvpa_mode_e op,
                             input logic [DATA_W-1:0] data);
    start          <= 1'b1;
    byte_address_i <= addr;
    mode_i         <= op;
    write_data_i   <= data;
    do @(negedge clk_i); while (!req_taken);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic set_color(input logic [1:0] cm);
    drain_results();
    repeat (4) @(negedge clk_i);
    color_mode_we_i <= 1'b1;
    color_mode_i    <= cm;
    @(negedge clk_i);
    color_mode_we_i <= 1'b0;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned win;
    if ($urandom_range(0, 7) == 0) return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    win = $urandom_range(0, 3);
    return ADDR_W'((win << WIN_SHIFT) | (hot_idx[$urandom_range(0, HOT_WORDS - 1)] << 1)
                   | $urandom_range(0, 1));
  endfunction

  initial begin
    logic [1:0] seg_color [SEGMENTS];
    int         idle_pct;
    seg_color = '{COLOR_16, COLOR_256, COLOR_RSVD, COLOR_65K,
                  COLOR_256, COLOR_16, COLOR_65K, COLOR_256};
    rst_ni          = 1'b0;
    color_mode_we_i = 1'b0;
    color_mode_i    = COLOR_16;
    start           = 1'b0;
    byte_address_i  = '0;
    mode_i          = MODE_RD_BYTE;
    write_data_i    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_color(COLOR_16);

    // sixteen colors: nibble pages, upper byte writes do nothing
    send_access(21'h000000, MODE_RD_WORD, 16'h0000);
    send_access(21'h1FFFFF, MODE_WR_WORD, 16'hFFFF);
    send_access(21'h1FFFFE, MODE_RD_WORD, 16'h0000);
    send_access(21'h1FFFFE, MODE_RD_BYTE, 16'h0000);
    send_access(21'h1FFFFF, MODE_RD_BYTE, 16'h0000);
    send_access(21'h000001, MODE_WR_BYTE, 16'h00A5);
    send_access(21'h080000, MODE_WR_BYTE, 16'hFFFF);
    send_access(21'h080001, MODE_RD_WORD, 16'h0000);
    send_access(21'h100000, MODE_WR_WORD, 16'h1234);
    send_access(21'h000000, MODE_RD_WORD, 16'h0000);
    set_color(COLOR_256);
    send_access(21'h080002, MODE_WR_WORD, 16'hBEEF);
    send_access(21'h000003, MODE_WR_BYTE, 16'hFF5A);
    send_access(21'h180002, MODE_RD_WORD, 16'h0000);
    send_access(21'h000002, MODE_RD_BYTE, 16'h0000);
    send_access(21'h000003, MODE_RD_BYTE, 16'h0000);
    set_color(COLOR_65K);
    send_access(21'h000004, MODE_WR_WORD, 16'hFFFF);
    send_access(21'h100004, MODE_WR_BYTE, 16'h0000);
    send_access(21'h180005, MODE_WR_BYTE, 16'h000F);
    send_access(21'h080004, MODE_RD_WORD, 16'h0000);
    send_access(21'h000004, MODE_RD_BYTE, 16'h0000);
    send_access(21'h000005, MODE_RD_BYTE, 16'h0000);
    send_access(21'h1FFFFE, MODE_WR_WORD, 16'h0000);
    send_access(21'h1FFFFF, MODE_RD_WORD, 16'h0000);
    set_color(COLOR_RSVD);
    send_access(21'h080003, MODE_RD_WORD, 16'h0000);
    send_access(21'h000003, MODE_WR_WORD, 16'h5555);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_color(seg_color[seg]);
      idle_pct = (seg < 3) ? 28 : (seg < 6) ? 76 : 0;
      hot_idx[0] = 0;
      hot_idx[1] = VRAM_WORDS - 1;
      for (int h = 2; h < HOT_WORDS; h++) hot_idx[h] = $urandom_range(0, VRAM_WORDS - 1);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(0, 99) < idle_pct) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk_i);
        end else if ($urandom_range(0, 59) == 0) begin
          drain_results();
        end
        send_access(pick_address(), gvpa_mode_e'($urandom_range(0, 3)),
                    DATA_W'($urandom_range(0, 65535)));
      end
    end

    drain_results();
    repeat (5) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
